// File: sv/pctm_pkg.sv
`timescale 1ns / 1ps

package pctm_pkg;

  // fixed field widths
  localparam int DATA_W = 16;
  localparam int MOD_W  = 3;

  typedef logic [DATA_W-1:0] sample_t;
  typedef logic [MOD_W-1:0]  mod_t;

  // cutoff after reset, 50.0 V
  localparam sample_t CUTOFF_RST = 16'd500;

endpackage

// File: sv/pctm_ram.sv
`timescale 1ns / 1ps

module pctm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pctm_div.sv
`timescale 1ns / 1ps

module pctm_div #(
  parameter int SW  = 19,
  parameter int DIV = 6
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SW-1:0]     sum_i,
  output pctm_pkg::sample_t quot_o
);
  import pctm_pkg::*;

  // reciprocal scaled so the first estimate is low by at most one
  localparam int K  = SW + 5;
  localparam int MW = K + 1;
  localparam int PW = SW + MW;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << K) / DIV);
  localparam logic [SW-1:0] DIV_W = SW'(DIV);

  logic [SW-1:0] sum_q;
  logic [PW-1:0] prod_q;
  sample_t       q0;
  logic [SW-1:0] rem;

  // multiply by the reciprocal, registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sum_i;
      prod_q <= PW'(sum_i) * PW'(RECIP);
    end
  end

  // remainder check corrects the estimate by one
  always_comb begin
    q0     = prod_q[K+DATA_W-1:K];
    rem    = sum_q - SW'(q0) * DIV_W;
    quot_o = (rem >= DIV_W) ? q0 + 1'b1 : q0;
  end

endmodule

// File: sv/per_channel_trimmed_mean_filter.sv
`timescale 1ns / 1ps

// Per-module trimmed-mean filter for voltage/current readings. Each input word
// carries a module index and one voltage and one current sample; voltages under
// the cutoff register read as zero and force the current to zero. Samples are
// shifted into the module's WINDOW-deep windows (zero after reset) and each
// output word gives the window mean with one smallest and one largest sample
// dropped, truncated. Indexes of MODULES or more touch no window and return
// zeros. One word is accepted per cycle, back to back, while the output is not
// stalled. The stages are: window row read from memory, window update plus
// sum/min/max, reciprocal multiply, and the output register. Write the cutoff only while idle.
module per_channel_trimmed_mean_filter #(
  parameter int MODULES = 8,
  parameter int WINDOW  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  pctm_pkg::sample_t cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pctm_pkg::mod_t    module_req_i,
  input  pctm_pkg::sample_t voltage_sample_i,
  input  pctm_pkg::sample_t current_sample_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pctm_pkg::mod_t    module_out_o,
  output pctm_pkg::sample_t filtered_voltage_o,
  output pctm_pkg::sample_t filtered_current_o
);
  import pctm_pkg::*;

  localparam int AW = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int SW = DATA_W + $clog2(WINDOW);
  localparam int RW = WINDOW * DATA_W;

  typedef logic [WINDOW-1:0][DATA_W-1:0] row_t;

  // sum of the window less one minimum and one maximum
  function automatic logic [SW-1:0] trim_sum(row_t r);
    logic [SW-1:0] acc;
    sample_t       lo;
    sample_t       hi;
    acc = '0;
    lo  = '1;
    hi  = '0;
    for (int k = 0; k < WINDOW; k++) begin
      acc = acc + SW'(r[k]);
      if (r[k] < lo) lo = r[k];
      if (r[k] > hi) hi = r[k];
    end
    return acc - SW'(lo) - SW'(hi);
  endfunction

  sample_t cutoff_q;

  logic    s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic    s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic    in_acc;
  mod_t    s1_mod_q, s2_mod_q, s3_mod_q, out_mod_q;
  sample_t s1_volt_q, s1_curr_q;
  logic    s1_rowvld_q;

  logic [2**AW-1:0] row_vld_q;
  logic             fwd_vld_q;
  logic [AW-1:0]    fwd_addr_q;
  row_t             fwd_vrow_q, fwd_crow_q;

  logic [AW-1:0] rd_addr, s1_addr;
  logic [RW-1:0] vrd_data, crd_data;
  logic          s1_in_range, s1_fwd, wr_en;
  sample_t       v_eff, c_eff;
  row_t          vold, cold, vnew, cnew;
  logic [SW-1:0] vsum, csum;
  logic [SW-1:0] s2_vsum_q, s2_csum_q;
  sample_t       vquot, cquot;
  sample_t       out_volt_q, out_curr_q;

  // stage handshake, a stage takes a word when empty or draining
  assign out_rdy    = !out_vld_q || out_ready_i;
  assign s3_rdy     = !s3_vld_q || out_rdy;
  assign s2_rdy     = !s2_vld_q || s3_rdy;
  assign s1_rdy     = !s1_vld_q || s2_rdy;
  assign in_ready_o = s1_rdy;
  assign in_acc     = in_valid_i && s1_rdy;

  // cutoff register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
    end else if (cfg_we_i) begin
      cutoff_q <= cfg_wdata_i;
    end
  end

  // window rows live in memory, one row per module
  assign rd_addr = AW'(module_req_i);
  assign s1_addr = AW'(s1_mod_q);

  pctm_ram #(.WIDTH(RW), .DEPTH(MODULES)) u_vram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr),
    .wdata_i (vnew),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (vrd_data)
  );

  pctm_ram #(.WIDTH(RW), .DEPTH(MODULES)) u_cram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr),
    .wdata_i (cnew),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (crd_data)
  );

  // control of stage 1 and row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      row_vld_q <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_q <= in_valid_i;
      end
      if (wr_en) begin
        row_vld_q[s1_addr] <= 1'b1;
        fwd_vld_q          <= 1'b1;
      end
    end
  end

  // stage 1 payload, plus a copy of the last row written
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mod_q    <= module_req_i;
      s1_volt_q   <= voltage_sample_i;
      s1_curr_q   <= current_sample_i;
      s1_rowvld_q <= row_vld_q[rd_addr];
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr;
      fwd_vrow_q <= vnew;
      fwd_crow_q <= cnew;
    end
  end

  // apply cutoff, pick the freshest row, shift in the new samples
  always_comb begin
    s1_in_range = (32'(s1_mod_q) < MODULES);
    v_eff       = (s1_volt_q < cutoff_q) ? '0 : s1_volt_q;
    c_eff       = (v_eff == '0) ? '0 : s1_curr_q;
    s1_fwd      = fwd_vld_q && (fwd_addr_q == s1_addr);
    if (s1_fwd) begin
      vold = fwd_vrow_q;
      cold = fwd_crow_q;
    end else if (s1_rowvld_q) begin
      vold = vrd_data;
      cold = crd_data;
    end else begin
      vold = '0;
      cold = '0;
    end
    for (int k = 0; k < WINDOW - 1; k++) begin
      vnew[k] = vold[k+1];
      cnew[k] = cold[k+1];
    end
    vnew[WINDOW-1] = v_eff;
    cnew[WINDOW-1] = c_eff;
    wr_en = s1_vld_q && s2_rdy && s1_in_range;
    vsum  = s1_in_range ? trim_sum(vnew) : '0;
    csum  = s1_in_range ? trim_sum(cnew) : '0;
  end

  // stages 2, 3 and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_vld_q <= s1_vld_q;
      end
      if (s3_rdy) begin
        s3_vld_q <= s2_vld_q;
      end
      if (out_rdy) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  // trimmed sums and module index down the pipe
  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_mod_q  <= s1_mod_q;
      s2_vsum_q <= vsum;
      s2_csum_q <= csum;
    end
    if (s3_rdy) begin
      s3_mod_q <= s2_mod_q;
    end
    if (out_rdy) begin
      out_mod_q  <= s3_mod_q;
      out_volt_q <= vquot;
      out_curr_q <= cquot;
    end
  end

  // divide by the number of samples kept
  pctm_div #(.SW(SW), .DIV(WINDOW - 2)) u_vdiv (
    .clk_i  (clk_i),
    .en_i   (s3_rdy),
    .sum_i  (s2_vsum_q),
    .quot_o (vquot)
  );

  pctm_div #(.SW(SW), .DIV(WINDOW - 2)) u_cdiv (
    .clk_i  (clk_i),
    .en_i   (s3_rdy),
    .sum_i  (s2_csum_q),
    .quot_o (cquot)
  );

  assign out_valid_o        = out_vld_q;
  assign module_out_o       = out_mod_q;
  assign filtered_voltage_o = out_volt_q;
  assign filtered_current_o = out_curr_q;

endmodule

// File: sv/pctm_checker.sv
`timescale 1ns / 1ps

module pctm_checker #(
  parameter int MODULES = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pctm_pkg::mod_t    module_out_o,
  input pctm_pkg::sample_t filtered_voltage_o,
  input pctm_pkg::sample_t filtered_current_o
);
  import pctm_pkg::*;

  // words held between input and output register
  localparam int PIPE_DEPTH = 4;

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(module_out_o) &&
      $stable(filtered_voltage_o) && $stable(filtered_current_o))
    else $error("output word changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0 && pend_q <= 3'(PIPE_DEPTH))
    else $error("output word without a pending input word");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(module_out_o) >= MODULES) |->
      filtered_voltage_o == '0 && filtered_current_o == '0)
    else $error("unknown module returned nonzero readings");

endmodule

bind per_channel_trimmed_mean_filter pctm_checker #(.MODULES(MODULES)) u_pctm_checker (.*);

// File: bench/per_channel_trimmed_mean_filter_tb.sv
`timescale 1ns / 1ps

module per_channel_trimmed_mean_filter_tb;

  import pctm_pkg::*;

  localparam int MODULES     = 8;
  localparam int WINDOW      = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    mod_t    mod;
    sample_t volt;
    sample_t curr;
  } reading_t;

  logic    clk_i            = 1'b0;
  logic    rst_ni           = 1'b0;
  logic    cfg_we_i         = 1'b0;
  sample_t cfg_wdata_i      = '0;
  logic    in_valid_i       = 1'b0;
  logic    in_ready_o;
  mod_t    module_req_i     = '0;
  sample_t voltage_sample_i = '0;
  sample_t current_sample_i = '0;
  logic    out_valid_o;
  logic    out_ready_i      = 1'b0;
  mod_t    module_out_o;
  sample_t filtered_voltage_o;
  sample_t filtered_current_o;

  // readings waiting to be driven, filtered words waiting to come out
  reading_t reading_q[$];
  reading_t filtered_q[$];

  // predicted block state
  sample_t cutoff_model;
  sample_t volt_win[MODULES][WINDOW];
  sample_t curr_win[MODULES][WINDOW];

  int      errors    = 0;
  int      cycle_cnt = 0;
  logic    no_idle   = 1'b0;
  mod_t    last_mod  = '0;

  per_channel_trimmed_mean_filter #(
    .MODULES(MODULES),
    .WINDOW (WINDOW)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .module_req_i      (module_req_i),
    .voltage_sample_i  (voltage_sample_i),
    .current_sample_i  (current_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .module_out_o      (module_out_o),
    .filtered_voltage_o(filtered_voltage_o),
    .filtered_current_o(filtered_current_o)
  );

  always #5 clk_i = ~clk_i;

  // random idle decision, true about 35 in 100 calls, never while no_idle is set
  function automatic logic take_gap();
    return !no_idle && ($urandom_range(0, 99) < 35);
  endfunction

  // cutoff, shift into the module windows, trimmed means of both windows
  function automatic reading_t next_filtered(mod_t mod, sample_t volt, sample_t curr);
    reading_t    res;
    logic [31:0] vsum;
    logic [31:0] csum;
    sample_t     vlo;
    sample_t     vhi;
    sample_t     clo;
    sample_t     chi;
    res.mod  = mod;
    res.volt = '0;
    res.curr = '0;
    if (int'(mod) >= MODULES) return res;
    if (volt < cutoff_model) volt = '0;
    if (volt == '0) curr = '0;
    for (int k = 0; k < WINDOW - 1; k++) begin
      volt_win[mod][k] = volt_win[mod][k+1];
      curr_win[mod][k] = curr_win[mod][k+1];
    end
    volt_win[mod][WINDOW-1] = volt;
    curr_win[mod][WINDOW-1] = curr;
    vsum = '0;
    csum = '0;
    vlo  = '1;
    clo  = '1;
    vhi  = '0;
    chi  = '0;
    for (int k = 0; k < WINDOW; k++) begin
      vsum += volt_win[mod][k];
      csum += curr_win[mod][k];
      if (volt_win[mod][k] < vlo) vlo = volt_win[mod][k];
      if (volt_win[mod][k] > vhi) vhi = volt_win[mod][k];
      if (curr_win[mod][k] < clo) clo = curr_win[mod][k];
      if (curr_win[mod][k] > chi) chi = curr_win[mod][k];
    end
    vsum = vsum - vlo - vhi;
    csum = csum - clo - chi;
    res.volt = sample_t'(vsum / (WINDOW - 2));
    res.curr = sample_t'(csum / (WINDOW - 2));
    return res;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        filtered_q.push_back(next_filtered(module_req_i, voltage_sample_i, current_sample_i));
      end
      if (reading_q.size() != 0 && !take_gap()) begin
        reading_t rd;
        rd = reading_q.pop_front();
        in_valid_i       <= 1'b1;
        module_req_i     <= rd.mod;
        voltage_sample_i <= rd.volt;
        current_sample_i <= rd.curr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word mod=%0d volt=%0d curr=%0d", $time,
                   module_out_o, filtered_voltage_o, filtered_current_o);
        end else begin
          reading_t exp_w;
          exp_w = filtered_q.pop_front();
          if (module_out_o !== exp_w.mod) begin
            errors++;
            $display("%0t: module_out expected %0d actual %0d", $time,
                     exp_w.mod, module_out_o);
          end
          if (filtered_voltage_o !== exp_w.volt) begin
            errors++;
            $display("%0t: filtered_voltage expected %0d actual %0d", $time,
                     exp_w.volt, filtered_voltage_o);
          end
          if (filtered_current_o !== exp_w.curr) begin
            errors++;
            $display("%0t: filtered_current expected %0d actual %0d", $time,
                     exp_w.curr, filtered_current_o);
          end
        end
      end
      out_ready_i <= !take_gap();
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** per_channel_trimmed_mean_filter: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (reading_q.size() != 0 || in_valid_i || filtered_q.size() != 0) @(negedge clk_i);
  endtask

  // cutoff write, only with the block idle
  task automatic write_cutoff(sample_t value);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    cutoff_model = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_reading(mod_t mod, sample_t volt, sample_t curr);
    reading_t rd;
    rd.mod  = mod;
    rd.volt = volt;
    rd.curr = curr;
    reading_q.push_back(rd);
  endtask

  // voltages cluster at zero, full scale and around the cutoff
  function automatic sample_t pick_voltage();
    int n;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3: begin
        n = int'(cutoff_model) + int'($urandom_range(0, 2)) - 1;
        if (n < 0) n = 0;
        if (n > 65535) n = 65535;
        return sample_t'(n);
      end
      4, 5:    return sample_t'($urandom_range(int'(cutoff_model), 65535));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_current();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // runs on one module keep its window churning, the rest is spread out
  task automatic add_random_readings(int count);
    mod_t mod;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) mod = last_mod;
      else mod = mod_t'($urandom_range(0, MODULES - 1));
      last_mod = mod;
      add_reading(mod, pick_voltage(), pick_current());
    end
  endtask

  initial begin
    cutoff_model = CUTOFF_RST;
    for (int m = 0; m < MODULES; m++) begin
      for (int k = 0; k < WINDOW; k++) begin
        volt_win[m][k] = '0;
        curr_win[m][k] = '0;
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset cutoff: zero voltage, just below and at the cutoff
    add_reading(3'd0, 16'd0, 16'hFFFF);
    add_reading(3'd0, 16'd499, 16'd1234);
    add_reading(3'd0, 16'd500, 16'd1);
    // full-scale window on the top module
    for (int i = 0; i < WINDOW; i++) add_reading(3'd7, 16'hFFFF, 16'hFFFF);
    // ties at both ends of the window
    add_reading(3'd3, 16'd600, 16'd300);
    add_reading(3'd3, 16'd600, 16'd300);

    // zero cutoff: only a zero reading is zero
    write_cutoff(16'd0);
    add_reading(3'd1, 16'd0, 16'd777);
    add_reading(3'd1, 16'd1, 16'd5);
    add_reading(3'd1, 16'hFFFF, 16'd0);

    // full-scale cutoff
    write_cutoff(16'hFFFF);
    add_reading(3'd2, 16'hFFFE, 16'd9);
    add_reading(3'd2, 16'hFFFF, 16'hFFFF);
    add_reading(3'd7, 16'hFFFF, 16'd0);

    // random phases over several cutoff settings
    write_cutoff(sample_t'($urandom));
    add_random_readings(270);
    write_cutoff(16'd0);
    no_idle = 1'b1;
    add_random_readings(260);
    wait_drained();
    no_idle = 1'b0;
    write_cutoff(16'hFFFF);
    add_random_readings(260);
    write_cutoff(CUTOFF_RST);
    add_random_readings(270);
    write_cutoff(16'd1);
    add_random_readings(270);
    write_cutoff(sample_t'($urandom_range(100, 1000)));
    add_random_readings(270);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (filtered_q.size() != 0) begin
      errors++;
      $display("%0t: %0d filtered words never arrived", $time, filtered_q.size());
    end
    if (errors == 0) begin
      $display("** per_channel_trimmed_mean_filter: PASSED **");
    end else begin
      $display("** per_channel_trimmed_mean_filter: FAILED **");
    end
    $finish;
  end

endmodule
